/* rtl/assert_macros.svh */
// Assertion macros for the checker module of the slab point location block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/splc_pkg.sv */
// Shared constants and codes of the slab point location search block.
package splc_pkg;

  localparam int unsigned MaxSegmentsDef = 64;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned HeightW = 17;
  localparam int unsigned RegionW = 7;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned StatusW = 2;

  localparam logic [HeightW-1:0] HeightOne = 17'h10000;

  localparam logic [ReqW-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [ReqW-1:0] REQ_APPEND = 2'd1;
  localparam logic [ReqW-1:0] REQ_LOCATE = 2'd2;

  localparam logic [StatusW-1:0] STAT_FOUND = 2'd0;
  localparam logic [StatusW-1:0] STAT_ACK   = 2'd1;
  localparam logic [StatusW-1:0] STAT_ERROR = 2'd2;

endpackage

/* rtl/slab_point_location_search_core.sv */
// Top level of the slab point location search block: segment table and search sequencer.
// Clear, append and error returns make no probe; a locate makes P probes,
// at most ceil(log2(count + 1)) for count stored segments.
// Each probe is one table read, one registered multiply and one compare in the shared unit.
// in_stall_o is high until the result enters the output register, longer if it is stalled.
// Reset empties the table (count to zero); table contents are not cleared.
module slab_point_location_search_core #(
  parameter int unsigned MAX_SEGMENTS = splc_pkg::MaxSegmentsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic        [splc_pkg::ReqW-1:0]    req_type_i,
  input  logic signed [splc_pkg::CoordW-1:0]  seg_bottom_x_i,
  input  logic signed [splc_pkg::CoordW-1:0]  seg_top_x_i,
  input  logic signed [splc_pkg::CoordW-1:0]  point_x_i,
  input  logic        [splc_pkg::HeightW-1:0] point_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [splc_pkg::RegionW-1:0] region_index_o,
  output logic        [splc_pkg::StatusW-1:0] status_o
);
  import splc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned IdxW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SEGMENTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_CMP,
    S_DONE
  } state_e;

  state_e state_q;
  logic [CntW-1:0] count_q, lo_q, hi_q;
  logic [CntW-1:0] lo_nx, hi_nx, mid_cnt;
  logic [CntW:0]   mid_sum;
  logic [IdxW-1:0] mid_idx;
  logic signed [CoordW-1:0] px_q;
  logic [HeightW-1:0] py_q;
  logic [RegionW-1:0] res_region_q, out_region_q;
  logic [StatusW-1:0] res_status_q, out_status_q;
  logic out_valid_q;
  logic accept, full, wr_en, left;

  logic [2*CoordW-1:0] seg_mem [MAX_SEGMENTS];
  logic [2*CoordW-1:0] rd_q;

  assign accept  = in_valid_i && !in_stall_o;
  assign full    = count_q == MaxCnt;
  assign wr_en   = accept && (req_type_i == REQ_APPEND) && !full;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_idx = mid_sum[IdxW:1];
  assign mid_cnt = CntW'(mid_idx);
  assign lo_nx   = left ? mid_cnt + CntW'(1) : lo_q;
  assign hi_nx   = left ? hi_q : mid_cnt;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      seg_mem[count_q[IdxW-1:0]] <= {seg_top_x_i, seg_bottom_x_i};
    end
    if (state_q == S_READ) begin
      rd_q <= seg_mem[mid_idx];
    end
  end

  splc_probe u_probe (
    .clk_i          (clk_i),
    .mul_en_i       (state_q == S_MUL),
    .seg_bottom_x_i (rd_q[CoordW-1:0]),
    .seg_top_x_i    (rd_q[2*CoordW-1:CoordW]),
    .point_x_i      (px_q),
    .point_y_i      (py_q),
    .left_o         (left)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      lo_q         <= '0;
      hi_q         <= '0;
      px_q         <= '0;
      py_q         <= '0;
      res_region_q <= '0;
      res_status_q <= STAT_ERROR;
      out_region_q <= '0;
      out_status_q <= STAT_ERROR;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_region_q <= '0;
            unique case (req_type_i)
              REQ_CLEAR: begin
                count_q      <= '0;
                res_status_q <= STAT_ACK;
                state_q      <= S_DONE;
              end
              REQ_APPEND: begin
                if (!full) begin
                  count_q      <= count_q + CntW'(1);
                  res_status_q <= STAT_ACK;
                end else begin
                  res_status_q <= STAT_ERROR;
                end
                state_q <= S_DONE;
              end
              REQ_LOCATE: begin
                if (count_q != '0) begin
                  lo_q    <= '0;
                  hi_q    <= count_q;
                  px_q    <= point_x_i;
                  py_q    <= (point_y_i > HeightOne) ? HeightOne : point_y_i;
                  state_q <= S_READ;
                end else begin
                  res_status_q <= STAT_ERROR;
                  state_q      <= S_DONE;
                end
              end
              default: begin
                res_status_q <= STAT_ERROR;
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_READ: state_q <= S_MUL;
        S_MUL:  state_q <= S_CMP;
        S_CMP: begin
          lo_q <= lo_nx;
          hi_q <= hi_nx;
          if (lo_nx < hi_nx) begin
            state_q <= S_READ;
          end else begin
            res_region_q <= RegionW'(lo_nx);
            res_status_q <= STAT_FOUND;
            state_q      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_region_q <= res_region_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = state_q != S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign region_index_o = out_region_q;
  assign status_o       = out_status_q;

endmodule

/* rtl/splc_probe.sv */
// Shared probe unit: registered interpolation product, then the left-of-point compare.
module splc_probe (
  input  logic                               clk_i,
  input  logic                               mul_en_i,
  input  logic signed [splc_pkg::CoordW-1:0] seg_bottom_x_i,
  input  logic signed [splc_pkg::CoordW-1:0] seg_top_x_i,
  input  logic signed [splc_pkg::CoordW-1:0] point_x_i,
  input  logic        [splc_pkg::HeightW-1:0] point_y_i,
  output logic                               left_o
);
  import splc_pkg::*;

  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned PyW   = HeightW + 1;
  localparam int unsigned ProdW = DiffW + PyW;
  localparam int unsigned SumW  = ProdW + 1;

  logic signed [DiffW-1:0] diff;
  logic signed [PyW-1:0]   py_s;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [CoordW-1:0] bx_q;
  logic signed [SumW-1:0]  lhs, rhs;

  assign diff   = {seg_top_x_i[CoordW-1], seg_top_x_i}
                - {seg_bottom_x_i[CoordW-1], seg_bottom_x_i};
  assign py_s   = {1'b0, point_y_i};
  assign prod_d = ProdW'(py_s) * ProdW'(diff);

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
      bx_q   <= seg_bottom_x_i;
    end
  end

  assign lhs = {{(SumW - CoordW - 16){point_x_i[CoordW-1]}}, point_x_i, 16'h0000};
  assign rhs = {{(SumW - CoordW - 16){bx_q[CoordW-1]}}, bx_q, 16'h0000}
             + {prod_q[ProdW-1], prod_q};

  assign left_o = lhs > rhs;

endmodule

/* rtl/splc_checker.sv */
// Port-level checker for the slab point location search block, with its bind.
`include "assert_macros.svh"

module splc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic        [splc_pkg::RegionW-1:0] region_index_o,
  input logic        [splc_pkg::StatusW-1:0] status_o
);
  import splc_pkg::*;

  // The block takes one item at a time, so it is busy right after an acceptance.
  `ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // Only the three defined status codes ever leave the block.
  `ASSERT_NOW(a_status_legal, out_valid_o,
              status_o == STAT_FOUND || status_o == STAT_ACK || status_o == STAT_ERROR)

  // The region is zero for every result that is not a finished query.
  `ASSERT_NOW(a_region_zero, out_valid_o && status_o != STAT_FOUND, region_index_o == '0)

  // A stalled result keeps its valid and payload.
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
               out_valid_o && $stable(region_index_o) && $stable(status_o))

endmodule

bind slab_point_location_search_core splc_checker u_splc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .region_index_o (region_index_o),
  .status_o       (status_o)
);

/* bench/tb.sv */
// Self-checking testbench for the slab point location search core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import splc_pkg::*;

  localparam int unsigned MaxSegs = MaxSegmentsDef;
  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;
  localparam int RandomItems = 1400;
  localparam int LongHold = 400;
  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic [RegionW-1:0] region;
    logic [StatusW-1:0] status;
  } answer_t;

  class region_tracker;
    logic signed [CoordW-1:0] bottoms[MaxSegs];
    logic signed [CoordW-1:0] tops[MaxSegs];
    int unsigned stored;
    int unsigned peak_stored;
    answer_t pending_answers[$];
    int failures;
    int found_cnt;
    int ack_cnt;
    int error_cnt;

    function new();
      stored = 0;
      peak_stored = 0;
      failures = 0;
      found_cnt = 0;
      ack_cnt = 0;
      error_cnt = 0;
    endfunction

    function answer_t predict(logic [ReqW-1:0] req, logic signed [CoordW-1:0] bx,
                              logic signed [CoordW-1:0] tx, logic signed [CoordW-1:0] px,
                              logic [HeightW-1:0] py);
      answer_t a;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      logic [HeightW-1:0] y;
      longint lhs;
      longint rhs;
      a.region = '0;
      a.status = STAT_ERROR;
      case (req)
        REQ_CLEAR: begin
          stored = 0;
          a.status = STAT_ACK;
        end
        REQ_APPEND: begin
          if (stored < MaxSegs) begin
            bottoms[stored] = bx;
            tops[stored] = tx;
            stored++;
            if (stored > peak_stored) peak_stored = stored;
            a.status = STAT_ACK;
          end
        end
        REQ_LOCATE: begin
          if (stored > 0) begin
            y = (py > HeightOne) ? HeightOne : py;
            lo = 0;
            hi = stored;
            lhs = longint'(px) * 65536;
            while (lo < hi) begin
              mid = (lo + hi) / 2;
              rhs = longint'(bottoms[mid]) * 65536
                    + longint'(y) * (longint'(tops[mid]) - longint'(bottoms[mid]));
              if (lhs > rhs) lo = mid + 1;
              else hi = mid;
            end
            a.region = RegionW'(lo);
            a.status = STAT_FOUND;
          end
        end
        default: ;
      endcase
      return a;
    endfunction

    function void note_request(logic [ReqW-1:0] req, logic signed [CoordW-1:0] bx,
                               logic signed [CoordW-1:0] tx, logic signed [CoordW-1:0] px,
                               logic [HeightW-1:0] py);
      pending_answers = {pending_answers, predict(req, bx, tx, px, py)};
    endfunction

    function void check_result(logic [RegionW-1:0] region, logic [StatusW-1:0] status);
      answer_t want;
      if (pending_answers.size() == 0) begin
        $error("unexpected result: region_index %0d status %0d", region, status);
        failures++;
      end else begin
        want = pending_answers.pop_front();
        if (region !== want.region) begin
          $error("region_index: expected %0d, got %0d", want.region, region);
          failures++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          failures++;
        end
        case (want.status)
          STAT_FOUND: found_cnt++;
          STAT_ACK: ack_cnt++;
          default: error_cnt++;
        endcase
      end
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [ReqW-1:0] req_type_i;
  logic signed [CoordW-1:0] seg_bottom_x_i;
  logic signed [CoordW-1:0] seg_top_x_i;
  logic signed [CoordW-1:0] point_x_i;
  logic [HeightW-1:0] point_y_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [RegionW-1:0] region_index_o;
  logic [StatusW-1:0] status_o;

  region_tracker tracker;
  int items_sent = 0;
  int hold_asks = 0;
  int holds_done = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;
  int cur_b[$];
  int cur_t[$];

  slab_point_location_search_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .req_type_i(req_type_i),
    .seg_bottom_x_i(seg_bottom_x_i),
    .seg_top_x_i(seg_top_x_i),
    .point_x_i(point_x_i),
    .point_y_i(point_y_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .region_index_o(region_index_o),
    .status_o(status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_x();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic send_item(input logic [ReqW-1:0] req, input int bx, input int tx,
                           input int px, input logic [HeightW-1:0] py);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    seg_bottom_x_i <= CoordW'(bx);
    seg_top_x_i <= CoordW'(tx);
    point_x_i <= CoordW'(px);
    point_y_i <= py;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    tracker.note_request(req_type_i, seg_bottom_x_i, seg_top_x_i, point_x_i, point_y_i);
    items_sent++;
    if (items_sent == 300 || items_sent == 900) hold_asks++;
  endtask

  task automatic locate_in_table();
    int kind;
    int i;
    int px;
    int diff;
    logic [HeightW-1:0] y;
    kind = $urandom_range(0, 9);
    px = rand_x();
    y = HeightW'($urandom_range(0, 65536));
    if (cur_b.size() != 0 && kind >= 3) begin
      i = $urandom_range(0, cur_b.size() - 1);
      if (kind < 6) begin
        diff = cur_t[i] - cur_b[i];
        case ($urandom_range(0, 2))
          0: begin
            y = '0;
            px = cur_b[i];
          end
          1: begin
            y = HeightOne;
            px = cur_t[i];
          end
          default: begin
            if (diff % 2 == 0) begin
              y = 17'h08000;
              px = cur_b[i] + diff / 2;
            end else begin
              y = '0;
              px = cur_b[i];
            end
          end
        endcase
        if ($urandom_range(0, 2) == 0) px = clamp16(px + int'($urandom_range(0, 2)) - 1);
      end else if (kind == 6) begin
        y = HeightW'($urandom_range(65537, 131071));
      end else begin
        px = clamp16(cur_b[i] + int'($urandom_range(0, 200)) - 100);
      end
    end
    send_item(REQ_LOCATE, $urandom, $urandom, px, y);
  endtask

  // Receiver: random stalls, quiet stretches, and a long hold when asked.
  initial begin
    int n;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(50, 150)) @(posedge clk_i);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_result(region_index_o, status_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: no item accepted for %0d cycles", WatchdogLimit);
        $display("slab_point_location_search_core regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int n;
    int extra;
    int cb;
    int ct;
    int i;
    tracker = new();
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    req_type_i <= REQ_CLEAR;
    seg_bottom_x_i <= '0;
    seg_top_x_i <= '0;
    point_x_i <= '0;
    point_y_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(REQ_LOCATE, 0, 0, 0, '0);
    send_item(REQ_UNUSED, -1, -1, -1, 17'h1FFFF);
    send_item(REQ_CLEAR, 0, 0, 0, '0);
    send_item(REQ_APPEND, -32768, 32767, 0, '0);
    send_item(REQ_LOCATE, 0, 0, 32767, '0);
    send_item(REQ_LOCATE, 0, 0, -32768, '0);
    send_item(REQ_LOCATE, 0, 0, 32767, HeightOne);
    send_item(REQ_LOCATE, 0, 0, -32768, 17'h1FFFF);
    send_item(REQ_LOCATE, 0, 0, 32767, 17'h1FFFF);
    send_item(REQ_LOCATE, 0, 0, 0, 17'h08000);
    send_item(REQ_CLEAR, 0, 0, 0, '0);
    send_item(REQ_APPEND, -100, 100, 0, '0);
    send_item(REQ_APPEND, 0, 0, 0, '0);
    send_item(REQ_APPEND, 200, 300, 0, '0);
    send_item(REQ_APPEND, 32767, -32768, 0, '0);
    send_item(REQ_LOCATE, 0, 0, 0, 17'h08000);
    send_item(REQ_LOCATE, 0, 0, 1, 17'h08000);
    send_item(REQ_LOCATE, 0, 0, 32767, '0);
    send_item(REQ_LOCATE, 0, 0, -32768, HeightOne);
    send_item(REQ_UNUSED, 0, 0, 0, '0);
    send_item(REQ_CLEAR, 0, 0, 0, '0);

    while (items_sent < RandomItems) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 9) != 0) begin
          send_item(REQ_CLEAR, $urandom, $urandom, $urandom, HeightW'($urandom));
          cur_b.delete();
          cur_t.delete();
        end
        i = $urandom_range(0, 99);
        if (i < 80) n = $urandom_range(1, 10);
        else if (i < 93) n = $urandom_range(11, 63);
        else n = MaxSegs;
        extra = (n == MaxSegs) ? $urandom_range(1, 3) : 0;
        cb = -32768 + int'($urandom_range(0, 65535 / (n + 1)));
        ct = -32768 + int'($urandom_range(0, 65535 / (n + 1)));
        for (i = 0; i < n; i++) begin
          send_item(REQ_APPEND, cb, ct, $urandom, HeightW'($urandom));
          cur_b = {cur_b, cb};
          cur_t = {cur_t, ct};
          cb = clamp16(cb + int'($urandom_range(0, 65535 / n)));
          ct = clamp16(ct + int'($urandom_range(0, 65535 / n)));
        end
        repeat (extra) send_item(REQ_APPEND, rand_x(), rand_x(), $urandom, HeightW'($urandom));
        repeat ($urandom_range(2, 12)) locate_in_table();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(ReqW'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                    HeightW'($urandom_range(0, 131071)));
        end
      end
    end
    in_valid_i <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d items: %0d locates answered, %0d clears or appends, %0d error returns.",
             items_sent, tracker.found_cnt, tracker.ack_cnt, tracker.error_cnt);
    $display("Largest table held %0d of %0d segments; long output holds applied: %0d.",
             tracker.peak_stored, MaxSegs, holds_done);
    if (tracker.failures == 0) begin
      $display("slab_point_location_search_core regression: pass");
    end else begin
      $display("slab_point_location_search_core regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/splc_pkg.sv
rtl/splc_probe.sv
rtl/slab_point_location_search_core.sv
rtl/splc_checker.sv
bench/tb.sv
